>>> design/node_association_table_macros.svh
// Assertion helpers used by the checker file.
`ifndef NODE_ASSOCIATION_TABLE_MACROS_SVH
`define NODE_ASSOCIATION_TABLE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, muted in reset.
`define NAT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, muted in reset.
`define NAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/nat_pkg.sv
`default_nettype none

package nat_pkg;

    localparam int NAT_MAX_NODES = 16;

    localparam logic [7:0]  CAP_SHORT_WANTED = 8'h80;
    localparam logic [15:0] ADDR_NONE        = 16'hFFFF;

    // configuration register indexes
    localparam logic REG_SHORT_BASE = 1'b0;
    localparam logic REG_ACCEPT     = 1'b1;

    localparam logic [15:0] SHORT_BASE_RESET = 16'd1;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 56;
    localparam int COUNT_W    = 5;

    typedef enum logic [1:0] {
        REQ_JOIN = 2'd0,
        REQ_DATA = 2'd1,
        REQ_READ = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_SUCCESS = 2'd0,
        ST_DENIED  = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    // request word travelling down the cell row, with the result gathered so far
    typedef struct packed {
        logic        vld;
        t_req        rtype;
        logic [31:0] lo;
        logic [31:0] hi;
        logic        cap_ok;
        logic        join_ok;
        logic [15:0] src;
        logic        seq_ok;
        logic [7:0]  pwr_in;
        logic [7:0]  lqi_in;
        logic [3:0]  idx;
        logic        found;
        logic        hit;
        logic [15:0] addr;
        logic [15:0] cnt;
        logic [7:0]  pwr;
        logic [7:0]  lqi;
    } t_tok;

    // new-entry write broadcast to the cells
    typedef struct packed {
        logic        we;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [15:0] short_addr;
    } t_alloc;

    typedef struct packed {
        logic [7:0]         lqi;
        logic [7:0]         pwr;
        logic [15:0]        cnt;
        logic [COUNT_W-1:0] count;
        logic               hit;
        logic [15:0]        addr;
        t_status            status;
    } t_res;

endpackage

`default_nettype wire

>>> design/nat_cell.sv
`default_nettype none

module nat_cell import nat_pkg::*; #(
    parameter int MAX_NODES = NAT_MAX_NODES,
    parameter int ENTRY_IDX = 0
) (
    input  wire  logic                               i_clk,
    input  wire  logic                               i_rst_n,
    input  wire  logic [$clog2(MAX_NODES + 1)-1:0]   i_used,
    input  wire  t_tok                               i_tok,
    output t_tok                                     o_tok,
    input  wire  t_alloc                             i_alloc,
    input  wire  logic [((MAX_NODES > 1) ? $clog2(MAX_NODES) : 1)-1:0] i_alloc_idx
);

    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    logic [31:0] r_lo;
    logic [31:0] r_hi;
    logic [15:0] r_short;
    logic [15:0] r_cnt;
    logic [7:0]  r_pwr;
    logic [7:0]  r_lqi;
    t_tok        r_tok;
    t_tok        n_tok;

    logic        in_use;
    logic        join_hit;
    logic        data_hit;
    logic        read_hit;
    logic        alloc_me;
    logic [15:0] cnt_inc;

    assign in_use   = CNT_W'(ENTRY_IDX) < i_used;
    assign cnt_inc  = r_cnt + 16'd1;
    assign alloc_me = i_alloc.we && (i_alloc_idx == IDX_W'(ENTRY_IDX));

    // first match wins for joins, last match wins for data frames
    assign join_hit = i_tok.vld && (i_tok.rtype == REQ_JOIN) && i_tok.join_ok &&
                      !i_tok.found && in_use && (r_lo == i_tok.lo) && (r_hi == i_tok.hi);
    assign data_hit = i_tok.vld && (i_tok.rtype == REQ_DATA) && i_tok.seq_ok &&
                      in_use && (r_short == i_tok.src);
    assign read_hit = i_tok.vld && (i_tok.rtype == REQ_READ) && in_use &&
                      (ENTRY_IDX < 16) && (i_tok.idx == 4'(ENTRY_IDX));

    always_comb begin
        n_tok = i_tok;
        if (join_hit) begin
            n_tok.found = 1'b1;
            n_tok.addr  = r_short;
        end else if (data_hit) begin
            n_tok.hit  = 1'b1;
            n_tok.addr = r_short;
            n_tok.cnt  = cnt_inc;
            n_tok.pwr  = i_tok.pwr_in;
            n_tok.lqi  = i_tok.lqi_in;
        end else if (read_hit) begin
            n_tok.hit  = 1'b1;
            n_tok.addr = r_short;
            n_tok.cnt  = r_cnt;
            n_tok.pwr  = r_pwr;
            n_tok.lqi  = r_lqi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (alloc_me) begin
            r_lo    <= i_alloc.lo;
            r_hi    <= i_alloc.hi;
            r_short <= i_alloc.short_addr;
            r_cnt   <= 16'd0;
            r_pwr   <= 8'd0;
            r_lqi   <= 8'd0;
        end else if (join_hit) begin
            r_cnt <= 16'd0;
            r_pwr <= 8'd0;
            r_lqi <= 8'd0;
        end else if (data_hit) begin
            r_cnt <= cnt_inc;
            r_pwr <= i_tok.pwr_in;
            r_lqi <= i_tok.lqi_in;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

>>> design/node_association_table.sv
// Node association table. Holds up to MAX_NODES joined nodes, one per cell in
// a row of cells; each cell keeps one entry (extended address, short address,
// receive count, last power byte and link quality). A request word enters the
// first cell and moves one cell per clock; each cell compares and updates its
// own entry as the word passes and folds its answer into the word. Join
// requests (tuser 0) reuse a known entry or allocate base + count at the end of
// the row; data frames (tuser 1) with seq_ok set update every entry with a
// matching short address; reads (tuser 2) return one entry. Each request
// yields exactly one result word. The next request is taken only once the
// last is through: it loads the row head, walks down the cell row, is captured
// at the row tail, and then the result is finished and a new entry written,
// which waits while an earlier result still stalls on the master side.
// s_axis_tready stays high while a finished result waits on the master side.
// Configuration writes must only be issued while no request is in flight.
`default_nettype none

module node_association_table import nat_pkg::*; #(
    parameter int MAX_NODES = NAT_MAX_NODES
) (
    input  wire  logic                  i_clk,
    input  wire  logic                  i_rst_n,
    // config write port
    input  wire  logic                  i_cfg_we,
    input  wire  logic                  i_cfg_idx,
    input  wire  logic [15:0]           i_cfg_data,
    // request side
    input  wire  logic                  s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata from bit 0: ext_addr_lo[31:0], ext_addr_hi[31:0], capability[7:0],
    // src_short_addr[15:0], seq_ok, power_byte[7:0], link_quality[7:0],
    // entry_index[3:0], 3 zero bits
    input  wire  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: req_type[1:0]
    input  wire  logic [1:0]            s_axis_tuser,
    // result side
    output logic                        m_axis_tvalid,
    input  wire  logic                  m_axis_tready,
    // tdata from bit 0: assoc_status[1:0], short_addr[15:0], hit,
    // node_count[4:0], recv_count[15:0], last_power[7:0], last_lqi[7:0]
    output logic [OUT_DATA_W-1:0]       m_axis_tdata
);

    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    // config registers
    logic [15:0] r_base;
    logic        r_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= SHORT_BASE_RESET;
            r_accept <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SHORT_BASE: r_base   <= i_cfg_data;
                REG_ACCEPT:     r_accept <= i_cfg_data[0];
                default:        ;
            endcase
        end
    end

    // control
    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_used;
    logic [CNT_W-1:0] n_used;
    t_tok             r_head;
    t_tok             n_head;
    t_tok             r_tail;
    t_res             r_out;
    t_res             n_res;
    logic             r_out_vld;
    logic             s_acc;
    logic             finish;
    t_alloc           alloc;
    logic [15:0]      new_addr;
    logic             room;

    t_tok             chain [MAX_NODES+1];

    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign room     = r_used < CNT_W'(MAX_NODES);
    assign new_addr = r_base + 16'(r_used);

    // build the word that enters the row
    always_comb begin
        n_head         = '0;
        n_head.vld     = 1'b1;
        n_head.rtype   = t_req'(s_axis_tuser);
        n_head.lo      = s_axis_tdata[31:0];
        n_head.hi      = s_axis_tdata[63:32];
        n_head.cap_ok  = (s_axis_tdata[71:64] & CAP_SHORT_WANTED) != 8'd0;
        n_head.join_ok = r_accept && n_head.cap_ok;
        n_head.src     = s_axis_tdata[87:72];
        n_head.seq_ok  = s_axis_tdata[88];
        n_head.pwr_in  = s_axis_tdata[96:89];
        n_head.lqi_in  = s_axis_tdata[104:97];
        n_head.idx     = s_axis_tdata[108:105];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.vld <= 1'b0;
        end else if (s_acc) begin
            r_head <= n_head;
        end else begin
            r_head.vld <= 1'b0;
        end
    end

    assign chain[0] = r_head;

    genvar g;
    generate
        for (g = 0; g < MAX_NODES; g++) begin : g_cell
            nat_cell #(
                .MAX_NODES (MAX_NODES),
                .ENTRY_IDX (g)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_used      (r_used),
                .i_tok       (chain[g]),
                .o_tok       (chain[g+1]),
                .i_alloc     (alloc),
                .i_alloc_idx (r_used[IDX_W-1:0])
            );
        end
    endgenerate

    // row tail is captured once; payload only
    always_ff @(posedge i_clk) begin
        if (r_state == S_RUN && chain[MAX_NODES].vld) begin
            r_tail <= chain[MAX_NODES];
        end
    end

    // finish the result, decide on allocation
    always_comb begin
        n_state          = r_state;
        s_axis_tready    = 1'b0;
        finish           = 1'b0;
        n_used           = r_used;
        alloc            = '0;
        alloc.lo         = r_tail.lo;
        alloc.hi         = r_tail.hi;
        alloc.short_addr = new_addr;
        n_res            = '0;
        n_res.status     = ST_IGNORED;
        n_res.hit        = r_tail.hit;
        n_res.addr       = r_tail.addr;
        n_res.cnt        = r_tail.cnt;
        n_res.pwr        = r_tail.pwr;
        n_res.lqi        = r_tail.lqi;

        if (r_tail.rtype == REQ_JOIN) begin
            n_res.hit = 1'b0;
            n_res.cnt = 16'd0;
            n_res.pwr = 8'd0;
            n_res.lqi = 8'd0;
            if (!r_accept) begin
                n_res.status = ST_IGNORED;
                n_res.addr   = ADDR_NONE;
            end else if (!r_tail.cap_ok) begin
                n_res.status = ST_DENIED;
                n_res.addr   = ADDR_NONE;
            end else if (r_tail.found) begin
                n_res.status = ST_SUCCESS;
            end else if (room) begin
                n_res.status = ST_SUCCESS;
                n_res.addr   = new_addr;
                alloc.we     = 1'b1;
                n_used       = CNT_W'(r_used + 1'b1);
            end else begin
                n_res.status = ST_DENIED;
                n_res.addr   = ADDR_NONE;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (chain[MAX_NODES].vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || m_axis_tready) begin
                    finish  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (!finish) begin
            alloc.we = 1'b0;
            n_used   = r_used;
        end
        n_res.count = COUNT_W'(n_used);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (finish) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

endmodule

`default_nettype wire

>>> design/nat_checker.sv
`default_nettype none
`include "node_association_table_macros.svh"

module nat_checker import nat_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic s_acc;
    logic m_hit;
    logic m_stall;
    logic m_hit_vld;
    logic m_deny_vld;
    logic [1:0]  m_status;
    logic [15:0] m_addr;

    assign s_acc      = s_axis_tvalid && s_axis_tready;
    assign m_status   = m_axis_tdata[1:0];
    assign m_addr     = m_axis_tdata[17:2];
    assign m_hit      = m_axis_tdata[18];
    assign m_stall    = m_axis_tvalid && !m_axis_tready;
    assign m_hit_vld  = m_axis_tvalid && m_hit;
    assign m_deny_vld = m_axis_tvalid && (m_status == ST_DENIED);

    // a stalled result word holds
    `NAT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_stall, m_axis_tvalid && $stable(m_axis_tdata))
    // one request in flight: no second accept right after one
    `NAT_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, s_acc, !s_axis_tready)
    // hits only come from data frames and reads, never from joins
    `NAT_ASSERT_NOW(a_hit_not_join, i_clk, i_rst_n, m_hit_vld, m_status == ST_IGNORED)
    // a denied join always carries the no-address code
    `NAT_ASSERT_NOW(a_denied_addr, i_clk, i_rst_n, m_deny_vld, m_addr == ADDR_NONE)

endmodule

bind node_association_table nat_checker u_nat_checker (.*);

`default_nettype wire
